/* rtl/md5k_pkg.sv */
package md5k_pkg;

	localparam int KeyCharsDefault = 5;
	localparam int Radix = 62;
	localparam int IndexWidth = 30;
	localparam int TextWidth = 40;
	localparam int WordWidth = 32;
	localparam int CfgIdxWidth = 2;
	localparam int DigitWidth = 6;

	localparam logic [CfgIdxWidth-1:0] REG_TARGET_A = 2'd0;
	localparam logic [CfgIdxWidth-1:0] REG_TARGET_B = 2'd1;
	localparam logic [CfgIdxWidth-1:0] REG_TARGET_C = 2'd2;
	localparam logic [CfgIdxWidth-1:0] REG_TARGET_D = 2'd3;

	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;

	typedef logic [31:0] word_t;
	typedef logic [DigitWidth-1:0] digit_t;

	typedef struct packed {
		word_t a;
		word_t b;
		word_t c;
		word_t d;
	} md5_state_t;

	function automatic logic [7:0] glyph(input digit_t v);
		logic [7:0] r;
		if (v < 6'd26)
			r = 8'h61 + {2'b00, v};
		else if (v < 6'd52)
			r = 8'h41 + {2'b00, v} - 8'd26;
		else
			r = 8'h30 + {2'b00, v} - 8'd52;
		return r;
	endfunction

	function automatic word_t addend(input logic [5:0] i);
		word_t k;
		case (i)
			6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
			6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
			6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
			6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
			6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
			6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
			6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
			6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
			6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
			6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
			6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
			6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
			default: k = 32'heb86d391;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] rot_amount(input logic [5:0] i);
		logic [4:0] s;
		case ({i[5:4], i[1:0]})
			4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
			4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
			4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
			4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
		endcase
		return s;
	endfunction

	function automatic logic [3:0] msg_sel(input logic [5:0] i);
		logic [3:0] g;
		case (i[5:4])
			2'd0: g = i[3:0];
			2'd1: g = 4'(5 * i[3:0] + 1);
			2'd2: g = 4'(3 * i[3:0] + 5);
			default: g = 4'(7 * i[3:0]);
		endcase
		return g;
	endfunction

endpackage

/* rtl/md5k_digit.sv */
// one base-62 digit per stage: remainder and quotient of a 30-bit value by 62
module md5k_digit import md5k_pkg::*; (
	input  logic [IndexWidth-1:0] num,
	output logic [IndexWidth-1:0] quo,
	output digit_t                rem
);
	// reciprocal multiply: floor(x*ceil(2^35/62)/2^35), then one correction step
	localparam logic [29:0] Recip = 30'((64'd1 << 35) / 62 + 1);
	logic [59:0] prod;
	logic [IndexWidth-1:0] q0;
	logic [IndexWidth+5:0] back;
	logic [IndexWidth:0] r0;

	always_comb begin
		prod = 60'(num) * 60'(Recip);
		// quotient of a 30-bit value by 62 fits in 25 bits
		q0 = {5'd0, prod[59:35]};
		back = 36'(q0) * 36'(Radix);
		r0 = 31'(num) - 31'(back);
		if (r0 >= 31'(Radix)) begin
			quo = q0 + 30'd1;
			rem = DigitWidth'(r0 - 31'(Radix));
		end else begin
			quo = q0;
			rem = DigitWidth'(r0);
		end
	end
endmodule

/* rtl/md5k_step.sv */
// one MD5 step, registered with valid, enable from the shared advance
module md5k_step import md5k_pkg::*; #(
	parameter logic [5:0] STEP = 6'd0
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  logic       vld_in,
	input  md5_state_t st_in,
	input  word_t      msg [16],
	output logic       vld_s1,
	output md5_state_t st_s1
);
	word_t f, t, rt, nb;
	logic [4:0] sh;

	always_comb begin
		case (STEP[5:4])
			2'd0: f = (st_in.b & st_in.c) | (~st_in.b & st_in.d);
			2'd1: f = (st_in.b & st_in.d) | (st_in.c & ~st_in.d);
			2'd2: f = st_in.b ^ st_in.c ^ st_in.d;
			default: f = st_in.c ^ (st_in.b | ~st_in.d);
		endcase
		t = st_in.a + f + msg[msg_sel(STEP)] + addend(STEP);
		sh = rot_amount(STEP);
		rt = (t << sh) | (t >> (6'd32 - {1'b0, sh}));
		nb = st_in.b + rt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (adv)
			vld_s1 <= vld_in;
	end

	always_ff @(posedge clk) begin
		if (adv)
			st_s1 <= '{a: st_in.d, b: nb, c: st_in.b, d: st_in.c};
	end
endmodule

/* rtl/md5_base62_key_match.sv */
// Fully pipelined base-62 key hasher: one key_index enters per clock and one result leaves
// per clock. Depth is KEY_CHARS digit stages, one message stage, 64 MD5 step stages and
// one compare stage; each MD5 step (a four-term 32-bit add and a rotate) sets the clock.
// A stall on a valid output freezes the whole pipeline and raises in_stall. The user must
// write targets through the config port only while the pipeline holds no item (unchecked).
module md5_base62_key_match import md5k_pkg::*; #(
	parameter int KEY_CHARS = KeyCharsDefault
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [IndexWidth-1:0]  key_index,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   is_match,
	output logic [TextWidth-1:0]   candidate_text,
	output logic [IndexWidth-1:0]  echoed_index,
	input  logic                   cfg_we,
	input  logic [CfgIdxWidth-1:0] cfg_index,
	input  logic [WordWidth-1:0]   cfg_data
);
	localparam int MsgBytes = 64;

	word_t tgt_a_q, tgt_b_q, tgt_c_q, tgt_d_q;
	logic adv;

	// output register moves when empty or taken
	assign adv = !out_valid || !out_stall;
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_a_q <= '0;
			tgt_b_q <= '0;
			tgt_c_q <= '0;
			tgt_d_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TARGET_A: tgt_a_q <= cfg_data;
				REG_TARGET_B: tgt_b_q <= cfg_data;
				REG_TARGET_C: tgt_c_q <= cfg_data;
				REG_TARGET_D: tgt_d_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// digit stages: least significant digit first, character KEY_CHARS-1-k
	logic                  dv_q   [KEY_CHARS+1];
	logic [IndexWidth-1:0] rest_q [KEY_CHARS+1];
	logic [IndexWidth-1:0] idx_q  [KEY_CHARS+1];
	logic [7:0]            chr_q  [KEY_CHARS+1][KEY_CHARS];

	always_comb begin
		dv_q[0] = in_valid;
		rest_q[0] = key_index;
		idx_q[0] = key_index;
		for (int p = 0; p < KEY_CHARS; p++)
			chr_q[0][p] = 8'h00;
	end

	for (genvar k = 0; k < KEY_CHARS; k++) begin : g_dig
		logic [IndexWidth-1:0] quo;
		digit_t rem, lead;
		md5k_digit u_dig (.num(rest_q[k]), .quo(quo), .rem(rem));
		// the leading digit wraps modulo 62
		assign lead = rem;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_q[k+1] <= 1'b0;
			else if (adv)
				dv_q[k+1] <= dv_q[k];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				rest_q[k+1] <= quo;
				idx_q[k+1] <= idx_q[k];
				for (int p = 0; p < KEY_CHARS; p++)
					chr_q[k+1][p] <= (p == KEY_CHARS-1-k) ? glyph(lead) : chr_q[k][p];
			end
		end
	end

	// message block build
	logic [7:0] blk [MsgBytes];
	word_t msg_c [16];
	always_comb begin
		for (int b = 0; b < MsgBytes; b++)
			blk[b] = 8'h00;
		for (int p = 0; p < KEY_CHARS; p++)
			blk[p] = chr_q[KEY_CHARS][p];
		blk[KEY_CHARS] = 8'h80;
		for (int w = 0; w < 16; w++)
			msg_c[w] = {blk[4*w+3], blk[4*w+2], blk[4*w+1], blk[4*w]};
		msg_c[14] = 32'(KEY_CHARS * 8);
	end

	logic       v_q  [65];
	md5_state_t st_q [65];
	word_t      msg_q [65][16];
	logic [IndexWidth-1:0] pidx_q [65];
	logic [TextWidth-1:0]  ptxt_q [65];
	logic [TextWidth-1:0]  txt_c;

	always_comb begin
		txt_c = '0;
		for (int p = 0; p < KEY_CHARS && p < 5; p++)
			txt_c[8*p +: 8] = chr_q[KEY_CHARS][p];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_q[0] <= 1'b0;
		else if (adv)
			v_q[0] <= dv_q[KEY_CHARS];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			st_q[0] <= '{a: IV_A, b: IV_B, c: IV_C, d: IV_D};
			msg_q[0] <= msg_c;
			pidx_q[0] <= idx_q[KEY_CHARS];
			ptxt_q[0] <= txt_c;
		end
	end

	for (genvar s = 0; s < 64; s++) begin : g_step
		md5k_step #(.STEP(6'(s))) u_step (
			.clk(clk), .arst_n(arst_n), .adv(adv),
			.vld_in(v_q[s]), .st_in(st_q[s]), .msg(msg_q[s]),
			.vld_s1(v_q[s+1]), .st_s1(st_q[s+1])
		);
		always_ff @(posedge clk) begin
			if (adv) begin
				msg_q[s+1] <= msg_q[s];
				pidx_q[s+1] <= pidx_q[s];
				ptxt_q[s+1] <= ptxt_q[s];
			end
		end
	end

	logic hit;
	assign hit = (st_q[64].a + IV_A == tgt_a_q) && (st_q[64].b + IV_B == tgt_b_q)
		&& (st_q[64].c + IV_C == tgt_c_q) && (st_q[64].d + IV_D == tgt_d_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (adv)
			out_valid <= v_q[64];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			is_match <= hit;
			candidate_text <= ptxt_q[64];
			echoed_index <= pidx_q[64];
		end
	end

	ap_stall_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall)) else $error("stall mismatch");
	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(echoed_index))
		else $error("result lost under stall");
	ap_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |=> out_valid == $past(v_q[64])) else $error("valid lost");
endmodule
